### hw/rtl/msic_pkg.sv
// shared types and constants of the motor speed integral control unit
`timescale 1ns / 1ps

package msic_pkg;

  localparam int GoalW   = 24;
  localparam int CountW  = 32;
  localparam int TimeW   = 32;
  localparam int SpeedW  = 32;
  localparam int DutyW   = 8;
  localparam int CprW    = 16;
  localparam int CfgIdxW = 1;
  localparam int CfgW    = 16;
  localparam int PowerW  = 9;
  localparam int GoalQW  = 17;
  localparam int ScaleW  = 26;
  localparam int ProdW   = CountW + ScaleW;
  localparam int NumW    = 65;
  localparam int DenW    = TimeW + CprW;
  localparam int ErrW    = 34;
  localparam int IncW    = ErrW - 7;
  localparam int SumW    = IncW + 1;
  localparam int StepW   = 5;

  localparam logic [CfgIdxW-1:0] CFG_COUNTS_PER_REV = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_REVERSE_COUNT  = 1'd1;

  // q8 rpm limits, the power limit and the rpm scale factor
  localparam logic signed [GoalW-1:0]  DEADBAND_Q8   = 24'sd12800;
  localparam logic signed [GoalW-1:0]  GOAL_LIMIT_Q8 = 24'sd38400;
  localparam logic signed [ErrW-1:0]   ERR_DEADBAND  = 34'sd1280;
  localparam logic signed [SumW-1:0]   POWER_LIMIT   = 28'sd255;
  localparam logic [ScaleW-1:0]        RPM_SCALE     = 26'd60000000;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_init;
    logic div_step;
    logic speed;
    logic err;
    logic update;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic dead;
    logic den_zero;
    logic ovf;
  } sts_t;

endpackage

### hw/rtl/motor_speed_integral_control_unit.sv
// top level of the motor speed integral control unit
`timescale 1ns / 1ps

// One word per control tick. A word whose goal lies inside the +-50 rpm deadband
// only passes through taking the word, the multiply and the result load, so its
// all-zero result comes without a divide, and it leaves all state alone.
// An active word takes the word, multiplies, sets up the divider, runs 32 steps of
// the restoring divider that measures the speed, then does the speed, error and
// integrator update steps and loads the result. The divider steps are skipped when
// the elapsed time or the counts per revolution is zero or the quotient does not
// fit in 32 bits. One word is in work at a time; the result register lets the
// next word in while a finished result still waits on the output, and the result
// load of the next word waits until that result is taken.

module motor_speed_integral_control_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [msic_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [msic_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // goal_speed, encoder_count, time_us
  input  logic [87:0]                  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // measured_speed, pwm_duty, drive_in1, drive_in2, rate_fault, zero fill
  output logic [47:0]                  m_axis_tdata
);
  import msic_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [SpeedW-1:0] speed;
  logic [DutyW-1:0]  duty;
  logic              in1;
  logic              in2;
  logic              fault;

  msic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  msic_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .goal_i     (s_axis_tdata[23:0]),
    .count_i    (s_axis_tdata[55:24]),
    .time_i     (s_axis_tdata[87:56]),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .speed_o    (speed),
    .duty_o     (duty),
    .in1_o      (in1),
    .in2_o      (in2),
    .fault_o    (fault)
  );

  assign m_axis_tdata = {5'd0, fault, in2, in1, duty, speed};

endmodule

### hw/rtl/msic_ctrl.sv
// controller state machine of the motor speed integral control unit
`timescale 1ns / 1ps

module msic_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  msic_pkg::sts_t sts_i,
  output msic_pkg::cmd_t cmd_o
);
  import msic_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_INIT = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_SPD  = 3'd4;
  localparam logic [2:0] ST_ERR  = 3'd5;
  localparam logic [2:0] ST_UPD  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             valid_q, valid_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    valid_d = valid_q && !out_ready_i;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = sts_i.dead ? ST_OUT : ST_INIT;
      end
      ST_INIT: begin
        step_d = '0;
        if (sts_i.den_zero || sts_i.ovf) begin
          state_d = ST_SPD;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + StepW'(1);
        if (step_q == '1) begin
          state_d = ST_SPD;
        end
      end
      ST_SPD: begin
        cmd_o.speed = 1'b1;
        state_d     = ST_ERR;
      end
      ST_ERR: begin
        cmd_o.err = 1'b1;
        state_d   = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        if (!valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          valid_d        = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = valid_q;

endmodule

### hw/rtl/msic_datapath.sv
// datapath of the motor speed integral control unit: measure, divide, integrate
`timescale 1ns / 1ps

module msic_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [msic_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [msic_pkg::CfgW-1:0]     cfg_data_i,
  input  logic [msic_pkg::GoalW-1:0]    goal_i,
  input  logic [msic_pkg::CountW-1:0]   count_i,
  input  logic [msic_pkg::TimeW-1:0]    time_i,
  input  msic_pkg::cmd_t                cmd_i,
  output msic_pkg::sts_t                sts_o,
  output logic [msic_pkg::SpeedW-1:0]   speed_o,
  output logic [msic_pkg::DutyW-1:0]    duty_o,
  output logic                          in1_o,
  output logic                          in2_o,
  output logic                          fault_o
);
  import msic_pkg::*;

  // configuration
  logic [CprW-1:0] cpr_q;
  logic            rev_q;

  // controller state
  logic signed [PowerW-1:0] power_q;
  logic [CountW-1:0]        last_cnt_q;
  logic [TimeW-1:0]         last_time_q;

  // per-word work registers
  logic                     dead_q;
  logic signed [GoalQW-1:0] goal_q;
  logic                     neg_q;
  logic [CountW-1:0]        mag_q;
  logic [TimeW-1:0]         dt_q;
  logic [NumW-1:0]          num_q;
  logic [DenW-1:0]          den_q;
  logic [DenW-1:0]          rem_q;
  logic [SpeedW-1:0]        lo_q;
  logic signed [SpeedW-1:0] speed_q;
  logic                     fault_q;
  logic signed [IncW-1:0]   inc_q;

  // output registers
  logic [SpeedW-1:0] out_speed_q;
  logic [DutyW-1:0]  out_duty_q;
  logic              out_in1_q;
  logic              out_in2_q;
  logic              out_fault_q;

  logic signed [GoalW-1:0]  goal_w;
  logic                     dead_w;
  logic signed [GoalQW-1:0] goal_clamp_w;
  logic [CountW-1:0]        cnt_w;
  logic [CountW-1:0]        dc_w;
  logic [ProdW-1:0]         prod_w;
  logic [DenW:0]            trial_w;
  logic                     qbit_w;
  logic                     sat_w;
  logic signed [SpeedW-1:0] speed_d;
  logic signed [ErrW-1:0]   err_w;
  logic signed [SumW-1:0]   sum_w;
  logic signed [PowerW-1:0] power_d;
  logic [PowerW-1:0]        power_neg_w;

  assign goal_w = $signed(goal_i);
  assign dead_w = (goal_w > -DEADBAND_Q8) && (goal_w < DEADBAND_Q8);

  always_comb begin
    if (goal_w > GOAL_LIMIT_Q8) begin
      goal_clamp_w = GOAL_LIMIT_Q8[GoalQW-1:0];
    end else if (goal_w < -GOAL_LIMIT_Q8) begin
      goal_clamp_w = GoalQW'(-GOAL_LIMIT_Q8);
    end else begin
      goal_clamp_w = goal_w[GoalQW-1:0];
    end
  end

  assign cnt_w  = rev_q ? (CountW'(0) - count_i) : count_i;
  assign dc_w   = cnt_w - last_cnt_q;
  assign prod_w = ProdW'(mag_q) * ProdW'(RPM_SCALE);

  // restoring divide, one quotient bit per step
  assign trial_w = {rem_q, lo_q[SpeedW-1]};
  assign qbit_w  = (trial_w >= {1'b0, den_q});

  assign sts_o.dead     = dead_q;
  assign sts_o.den_zero = (den_q == '0);
  assign sts_o.ovf      = (DenW'(num_q[NumW-1:SpeedW]) >= den_q);

  // quotient of 2^31 or more saturates
  assign sat_w = sts_o.ovf || lo_q[SpeedW-1];

  always_comb begin
    if (sts_o.den_zero) begin
      speed_d = '0;
    end else if (neg_q) begin
      speed_d = sat_w ? $signed({1'b1, {(SpeedW-1){1'b0}}}) : $signed(SpeedW'(0) - lo_q);
    end else begin
      speed_d = sat_w ? $signed({1'b0, {(SpeedW-1){1'b1}}}) : $signed(lo_q);
    end
  end

  assign err_w = ErrW'(goal_q) - ErrW'(speed_q);
  assign sum_w = SumW'(power_q) + SumW'(inc_q);

  always_comb begin
    if (sum_w > POWER_LIMIT) begin
      power_d = POWER_LIMIT[PowerW-1:0];
    end else if (sum_w < -POWER_LIMIT) begin
      power_d = PowerW'(-POWER_LIMIT);
    end else begin
      power_d = sum_w[PowerW-1:0];
    end
  end

  assign power_neg_w = PowerW'(0) - power_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q       <= CprW'(1);
      rev_q       <= 1'b0;
      power_q     <= '0;
      last_cnt_q  <= '0;
      last_time_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_COUNTS_PER_REV: cpr_q <= cfg_data_i[CprW-1:0];
          CFG_REVERSE_COUNT:  rev_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.load && !dead_w) begin
        last_cnt_q  <= cnt_w;
        last_time_q <= time_i;
      end
      if (cmd_i.update) begin
        power_q <= power_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dead_q <= dead_w;
      goal_q <= goal_clamp_w;
      neg_q  <= dc_w[CountW-1];
      mag_q  <= dc_w[CountW-1] ? (CountW'(0) - dc_w) : dc_w;
      dt_q   <= time_i - last_time_q;
    end
    if (cmd_i.mul) begin
      num_q <= {prod_w[NumW-9:0], 8'd0};
      den_q <= DenW'(dt_q) * DenW'(cpr_q);
    end
    if (cmd_i.div_init) begin
      rem_q <= DenW'(num_q[NumW-1:SpeedW]);
      lo_q  <= num_q[SpeedW-1:0];
    end
    if (cmd_i.div_step) begin
      rem_q <= qbit_w ? DenW'(trial_w - {1'b0, den_q}) : trial_w[DenW-1:0];
      lo_q  <= {lo_q[SpeedW-2:0], qbit_w};
    end
    if (cmd_i.speed) begin
      speed_q <= speed_d;
      fault_q <= sts_o.den_zero;
    end
    if (cmd_i.err) begin
      if ((err_w > -ERR_DEADBAND) && (err_w < ERR_DEADBAND)) begin
        inc_q <= '0;
      end else begin
        inc_q <= err_w[ErrW-1:7];
      end
    end
    if (cmd_i.out_load) begin
      if (dead_q) begin
        out_speed_q <= '0;
        out_duty_q  <= '0;
        out_in1_q   <= 1'b0;
        out_in2_q   <= 1'b0;
        out_fault_q <= 1'b0;
      end else begin
        out_speed_q <= speed_q;
        out_in1_q   <= power_q[PowerW-1];
        out_in2_q   <= !power_q[PowerW-1] && (power_q != '0);
        out_duty_q  <= power_q[PowerW-1] ? power_neg_w[DutyW-1:0] : power_q[DutyW-1:0];
        out_fault_q <= fault_q;
      end
    end
  end

  assign speed_o = out_speed_q;
  assign duty_o  = out_duty_q;
  assign in1_o   = out_in1_q;
  assign in2_o   = out_in2_q;
  assign fault_o = out_fault_q;

endmodule

### tb/tb_motor_speed_integral_control_unit.sv
// testbench of the motor speed integral control unit: directed, register and random ticks
`timescale 1ns / 1ps

module tb_motor_speed_integral_control_unit;
  import msic_pkg::*;

  localparam int CycleLimit = 600000;
  localparam longint unsigned RpmPerSec = 64'd60000000;

  typedef struct packed {
    logic               fault;
    logic               in2;
    logic               in1;
    logic [DutyW-1:0]   duty;
    logic signed [31:0] speed;
  } drive_word_t;

  typedef enum int {RxOpen, RxCoin, RxSparse, RxStarved} rx_pattern_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0]    cfg_data_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  // goal_speed, encoder_count, time_us
  logic [87:0]        s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  // measured_speed, pwm_duty, drive_in1, drive_in2, rate_fault, zero fill
  logic [47:0]        m_axis_tdata;

  motor_speed_integral_control_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // controller shadow state
  logic [CprW-1:0]   cpr_q = 16'd1;
  logic              rev_q = 1'b0;
  int                drive_pwr = 0;
  logic [CountW-1:0] last_cnt = '0;
  logic [TimeW-1:0]  last_tm = '0;

  drive_word_t pending_drive[$];
  drive_word_t got_word;
  drive_word_t want_word;
  int          errors = 0;
  int          cycles = 0;

  // sender and stimulus generator state
  bit                tx_bursty = 1'b1;
  int                burst_left = 0;
  logic [CountW-1:0] gen_cnt = '0;
  logic [TimeW-1:0]  gen_time = '0;

  rx_pattern_e rx_mode = RxOpen;
  int          rx_left = 0;

  function automatic drive_word_t compute_drive(input logic signed [GoalW-1:0] goal,
                                                input logic [CountW-1:0] cnt,
                                                input logic [TimeW-1:0] tm);
    drive_word_t       res;
    longint            g, spd, err, inc, p, pm;
    logic [CountW-1:0] c, dcw, negw;
    logic [TimeW-1:0]  dt;
    longint unsigned   mag, den, q, r, m;
    bit                neg, ok;
    res = '0;
    g = longint'(goal);
    if (g > -longint'(DEADBAND_Q8) && g < longint'(DEADBAND_Q8)) return res;
    if (g > longint'(GOAL_LIMIT_Q8)) g = longint'(GOAL_LIMIT_Q8);
    else if (g < -longint'(GOAL_LIMIT_Q8)) g = -longint'(GOAL_LIMIT_Q8);
    c = rev_q ? -cnt : cnt;
    dcw = c - last_cnt;
    dt = tm - last_tm;
    last_cnt = c;
    last_tm = tm;
    den = longint'(dt) * longint'(cpr_q);
    ok = (den != 0);
    spd = 0;
    if (ok) begin
      neg = dcw[CountW-1];
      negw = -dcw;
      mag = neg ? 64'(negw) : 64'(dcw);
      q = (mag * RpmPerSec) / den;
      r = (mag * RpmPerSec) % den;
      if (q >= (64'd1 << 23)) m = 64'd1 << 31;
      else m = (q << 8) + ((r << 8) / den);
      if (neg) begin
        if (m > (64'd1 << 31)) m = 64'd1 << 31;
        spd = -longint'(m);
      end else begin
        if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
        spd = longint'(m);
      end
    end
    err = g - spd;
    if (err > -longint'(ERR_DEADBAND) && err < longint'(ERR_DEADBAND)) err = 0;
    inc = err >>> 7;
    p = longint'(drive_pwr) + inc;
    if (p > longint'(POWER_LIMIT)) p = longint'(POWER_LIMIT);
    else if (p < -longint'(POWER_LIMIT)) p = -longint'(POWER_LIMIT);
    drive_pwr = int'(p);
    pm = (p < 0) ? -p : p;
    res.speed = spd[31:0];
    res.duty = pm[DutyW-1:0];
    res.in1 = (p < 0);
    res.in2 = (p > 0);
    res.fault = !ok;
    return res;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_word = m_axis_tdata[42:0];
      if (pending_drive.size() == 0) begin
        errors++;
        $display("%0t: unexpected word expected none got %h", $time, m_axis_tdata);
      end else begin
        want_word = pending_drive.pop_front();
        check_field("measured_speed", longint'(want_word.speed), longint'(got_word.speed));
        check_field("pwm_duty", want_word.duty, got_word.duty);
        check_field("drive_in1", want_word.in1, got_word.in1);
        check_field("drive_in2", want_word.in2, got_word.in2);
        check_field("rate_fault", want_word.fault, got_word.fault);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_motor_speed_integral_control_unit NOT OK");
      $finish;
    end
  end

  // output stall pattern
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_pattern_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 300);
    end
    rx_left--;
    case (rx_mode)
      RxOpen: begin
        m_axis_tready <= 1'b1;
      end
      RxCoin: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      RxSparse: begin
        m_axis_tready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        m_axis_tready <= ($urandom_range(0, 15) == 0);
      end
    endcase
  end

  task automatic send_tick(input logic [GoalW-1:0] goal, input logic [CountW-1:0] cnt,
                           input logic [TimeW-1:0] tm);
    int gap;
    if (burst_left == 0) begin
      gap = tx_bursty ? $urandom_range(1, 8) : 0;
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {tm, cnt, goal};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_drive.push_back(compute_drive(goal, cnt, tm));
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    if (idx == CFG_COUNTS_PER_REV) cpr_q = value;
    else if (idx == CFG_REVERSE_COUNT) rev_q = value[0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_controller(input logic [CprW-1:0] cpr, input logic rev);
    drain();
    write_reg(CFG_COUNTS_PER_REV, cpr);
    write_reg(CFG_REVERSE_COUNT, {15'd0, rev});
  endtask

  // plausible tick: speed near the goal or somewhere in the motor's range
  task automatic send_tracking_tick;
    logic signed [GoalW-1:0] goal;
    longint                  target, want_q8, dc;
    int unsigned             dt;
    goal = 24'($urandom_range(12800, 51200));
    if ($urandom_range(0, 1)) goal = -goal;
    target = longint'(goal);
    if (target > longint'(GOAL_LIMIT_Q8)) target = longint'(GOAL_LIMIT_Q8);
    if (target < -longint'(GOAL_LIMIT_Q8)) target = -longint'(GOAL_LIMIT_Q8);
    if ($urandom_range(0, 1)) want_q8 = target + $urandom_range(0, 5120) - 2560;
    else want_q8 = longint'($urandom_range(0, 120000)) - 60000;
    dt = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(100, 200000);
    dc = (want_q8 * longint'(dt) * longint'(cpr_q)) / (longint'(RpmPerSec) * 256);
    if (rev_q) dc = -dc;
    gen_cnt = gen_cnt + 32'(dc);
    gen_time = gen_time + dt;
    send_tick(goal, gen_cnt, gen_time);
  endtask

  task automatic send_noise_tick;
    logic signed [GoalW-1:0] goal;
    logic [CountW-1:0]       cnt;
    logic [TimeW-1:0]        tm;
    goal = 24'($urandom);
    cnt = $urandom;
    tm = $urandom;
    if ($urandom_range(0, 1)) goal = $signed(24'($urandom_range(0, 25598))) - 24'sd12799;
    send_tick(goal, cnt, tm);
    if (goal <= -DEADBAND_Q8 || goal >= DEADBAND_Q8) begin
      gen_cnt = cnt;
      gen_time = tm;
    end
  endtask

  task automatic test_deadband_and_extremes;
    tx_bursty = 1'b0;
    send_tick(24'd0, 32'd123, 32'd55);
    send_tick(24'd12799, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_tick(-24'sd12799, 32'h8000_0000, 32'd7);
    // zero elapsed time against the reset timestamp
    send_tick(24'd12800, 32'd0, 32'd0);
    send_tick(-24'sd12800, 32'd0, 32'd1000);
    // speed saturation both ways
    send_tick(24'h7F_FFFF, 32'h7FFF_FFFF, 32'd1001);
    send_tick(24'h80_0000, 32'hFFFF_FFFF, 32'd1002);
    send_tick(24'd38400, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    // count and time wrap
    send_tick(24'd38400, 32'h8000_0010, 32'h0000_0100);
    // error deadband edges around 100 rpm
    send_tick(24'd25600, 32'h8000_0010, 32'd1000000);
    send_tick(24'd26879, 32'h8000_0011, 32'd1600000);
    send_tick(24'd26880, 32'h8000_0012, 32'd2200000);
    send_tick(24'd24321, 32'h8000_0013, 32'd2800000);
    send_tick(24'd24320, 32'h8000_0014, 32'd3400000);
    // integrator saturation both ways
    repeat (3) send_tick(24'd38400, 32'h8000_0014, 32'd3400001);
    repeat (3) send_tick(-24'sd38400, 32'h8000_0014, 32'd3400002);
    send_tick(24'd12800, 32'h8000_0014, 32'd3400002);
    gen_cnt = 32'h8000_0014;
    gen_time = 32'd3400002;
  endtask

  task automatic test_register_settings;
    logic [CprW-1:0] cpr_set[6];
    logic            rev_set[6];
    cpr_set = '{16'hFFFF, 16'd1, 16'hFFFF, 16'd1, 16'h0000, 16'h0000};
    rev_set = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
    cpr_set[4] = 16'($urandom_range(2, 65534));
    cpr_set[5] = 16'($urandom_range(2, 65534));
    rev_set[4] = 1'($urandom_range(0, 1));
    rev_set[5] = 1'($urandom_range(0, 1));
    tx_bursty = 1'b1;
    for (int i = 0; i < 6; i++) begin
      set_controller(cpr_set[i], rev_set[i]);
      repeat (20) send_tracking_tick();
    end
  endtask

  task automatic test_random_ticks;
    logic [CprW-1:0] cpr;
    int              pick;
    for (int chunk = 0; chunk < 12; chunk++) begin
      case ($urandom_range(0, 3))
        0: cpr = 16'd1;
        1: cpr = 16'hFFFF;
        2: cpr = 16'($urandom_range(1, 2048));
        default: cpr = 16'($urandom_range(1, 65535));
      endcase
      set_controller(cpr, 1'($urandom_range(0, 1)));
      tx_bursty = (chunk % 3 != 2);
      repeat (100) begin
        pick = $urandom_range(0, 9);
        if (pick < 8) send_tracking_tick();
        else send_noise_tick();
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_deadband_and_extremes();
    test_register_settings();
    test_random_ticks();
    drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_motor_speed_integral_control_unit OK");
    end else begin
      $display("tb_motor_speed_integral_control_unit NOT OK");
    end
    $finish;
  end

endmodule
